[rtl/ipmac_pkg.sv]
package ipmac_pkg;

  localparam int CommandW = 1;
  localparam int IpW      = 32;
  localparam int MacW     = 48;
  localparam int StatusW  = 3;
  localparam int IndexW   = 6;
  localparam int CountW   = 7;

  localparam logic [StatusW-1:0] ST_HIT      = 3'd0;
  localparam logic [StatusW-1:0] ST_MISS     = 3'd1;
  localparam logic [StatusW-1:0] ST_UPDATED  = 3'd2;
  localparam logic [StatusW-1:0] ST_APPENDED = 3'd3;
  localparam logic [StatusW-1:0] ST_FULL     = 3'd4;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_ADD    = 1'b1;

  typedef struct packed {
    logic               load;
    logic               scan;
    logic               act;
    logic               finish;
    logic [StatusW-1:0] status;
  } ipmac_cmd_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic add;
    logic room;
  } ipmac_sts_t;

endpackage

[rtl/ip_to_mac_table_core.sv]
// channel   | handshake           | ports
// ----------+---------------------+-----------------------------------------------
// request   | start && !busy      | in_command, in_ip_address, in_mac_address
// result    | out_valid, 1 cycle  | out_status, out_mac_out, out_entry_index,
//           |                     | out_entry_count
//
// the result strobe follows the scan: the address store is read one entry a cycle
// through a registered port and compared in the cycle after the read; the scan stops
// at the first matching entry, or after the last filled entry when none matches or the
// table is empty, and the act and done states and the result register come after it
// busy stays high from the accepting edge until the result is presented
// synchronous active-low reset empties the table; stores hold no reset value
// the result is shown for one cycle and cannot be held off by the receiver
module ip_to_mac_table_core
  import ipmac_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [CommandW-1:0] in_command,
  input  logic [IpW-1:0]      in_ip_address,
  input  logic [MacW-1:0]     in_mac_address,
  output logic                out_valid,
  output logic [StatusW-1:0]  out_status,
  output logic [MacW-1:0]     out_mac_out,
  output logic [IndexW-1:0]   out_entry_index,
  output logic [CountW-1:0]   out_entry_count
);

  ipmac_cmd_t cmd;
  ipmac_sts_t sts;

  ipmac_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ipmac_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_command      (in_command),
    .in_ip_address   (in_ip_address),
    .in_mac_address  (in_mac_address),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_mac_out     (out_mac_out),
    .out_entry_index (out_entry_index),
    .out_entry_count (out_entry_count)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_result_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("busy dropped without a result");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == ST_MISS) || (out_status == ST_FULL)) |->
      (out_entry_index == '0) && (out_mac_out == '0))
    else $error("miss or full result carries non-zero fields");

endmodule

[rtl/ipmac_ctrl.sv]
module ipmac_ctrl
  import ipmac_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  ipmac_sts_t sts,
  output ipmac_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_ACT  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]         state_r;
  logic [1:0]         state_nxt;
  logic [StatusW-1:0] st_r;
  logic [StatusW-1:0] st_nxt;

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.done) begin
          state_nxt = S_ACT;
          if (sts.hit) begin
            st_nxt = sts.add ? ST_UPDATED : ST_HIT;
          end else if (!sts.add) begin
            st_nxt = ST_MISS;
          end else begin
            st_nxt = sts.room ? ST_APPENDED : ST_FULL;
          end
        end
      end
      S_ACT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_MISS;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign cmd.load   = start && (state_r == S_IDLE);
  assign cmd.scan   = (state_r == S_SCAN);
  assign cmd.act    = (state_r == S_ACT);
  assign cmd.finish = (state_r == S_DONE);
  assign cmd.status = st_r;

endmodule

[rtl/ipmac_dp.sv]
module ipmac_dp
  import ipmac_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ipmac_cmd_t          cmd,
  output ipmac_sts_t          sts,
  input  logic [CommandW-1:0] in_command,
  input  logic [IpW-1:0]      in_ip_address,
  input  logic [MacW-1:0]     in_mac_address,
  output logic                out_valid,
  output logic [StatusW-1:0]  out_status,
  output logic [MacW-1:0]     out_mac_out,
  output logic [IndexW-1:0]   out_entry_index,
  output logic [CountW-1:0]   out_entry_count
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1);

  logic [IpW-1:0]  addr_mem [TABLE_DEPTH];
  logic [MacW-1:0] mac_mem  [TABLE_DEPTH];

  logic [CommandW-1:0] cmd_r;
  logic [IpW-1:0]      ip_r;
  logic [MacW-1:0]     mac_in_r;
  logic [CntW-1:0]     count_r;
  logic [CntW-1:0]     rd_idx_r;
  logic                cmp_vld_r;
  logic [CntW-1:0]     cmp_idx_r;
  logic [IpW-1:0]      addr_q_r;
  logic [MacW-1:0]     mac_q_r;
  logic [IdxW-1:0]     where_r;
  logic                out_valid_r;
  logic [StatusW-1:0]  out_status_r;
  logic [MacW-1:0]     out_mac_r;
  logic [IndexW-1:0]   out_index_r;
  logic [CountW-1:0]   out_count_r;

  logic            cmp_hit;
  logic            rd_more;
  logic            do_append;
  logic            do_update;
  logic            mac_we;
  logic [IdxW-1:0] mac_wr_idx;
  logic [IdxW-1:0] app_idx;

  assign cmp_hit    = cmp_vld_r && (addr_q_r == ip_r);
  assign rd_more    = (rd_idx_r < count_r);
  assign app_idx    = count_r[IdxW-1:0];
  assign do_append  = cmd.act && (cmd.status == ST_APPENDED);
  assign do_update  = cmd.act && (cmd.status == ST_UPDATED);
  assign mac_we     = do_append || do_update;
  assign mac_wr_idx = do_append ? app_idx : where_r;

  assign sts.done = cmp_hit || (!cmp_vld_r && !rd_more);
  assign sts.hit  = cmp_hit;
  assign sts.add  = (cmd_r == CMD_ADD);
  assign sts.room = (count_r < CntW'(TABLE_DEPTH));

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_command;
      ip_r     <= in_ip_address;
      mac_in_r <= in_mac_address;
    end
  end

  // scan pipeline: read one entry a cycle, compare in the cycle after the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
    end else if (cmd.load) begin
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
    end else if (cmd.scan) begin
      cmp_vld_r <= rd_more;
      if (rd_more) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
    end else begin
      cmp_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && rd_more) begin
      cmp_idx_r <= rd_idx_r;
    end
    if (cmd.scan && cmp_hit) begin
      where_r <= cmp_idx_r[IdxW-1:0];
    end else if (do_append) begin
      where_r <= app_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (do_append) begin
      count_r <= count_r + 1'b1;
    end
  end

  // address store
  always_ff @(posedge clk) begin
    if (do_append) begin
      addr_mem[app_idx] <= ip_r;
    end
    if (cmd.scan && rd_more) begin
      addr_q_r <= addr_mem[rd_idx_r[IdxW-1:0]];
    end
  end

  // hardware address store
  always_ff @(posedge clk) begin
    if (mac_we) begin
      mac_mem[mac_wr_idx] <= mac_in_r;
    end
    if (cmd.act && (cmd.status == ST_HIT)) begin
      mac_q_r <= mac_mem[where_r];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= cmd.status;
      out_count_r  <= CountW'(count_r);
      out_mac_r    <= (cmd.status == ST_HIT) ? mac_q_r : '0;
      if ((cmd.status == ST_HIT) || (cmd.status == ST_UPDATED) ||
          (cmd.status == ST_APPENDED)) begin
        out_index_r <= IndexW'(where_r);
      end else begin
        out_index_r <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_mac_out     = out_mac_r;
  assign out_entry_index = out_index_r;
  assign out_entry_count = out_count_r;

endmodule

[bench/tb_ip_to_mac_table_core.sv]
module tb_ip_to_mac_table_core
  import ipmac_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableDepth  = 64;
  localparam int RandomItems = 1130;
  localparam int QuietTail   = 120;
  localparam int DrainCycles = 2 * (TableDepth + 5);
  localparam int CycleLimit  = 600000;

  typedef struct packed {
    logic [CommandW-1:0] command;
    logic [IpW-1:0]      ip;
    logic [MacW-1:0]     mac;
  } arp_request_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [MacW-1:0]    mac;
    logic [IndexW-1:0]  index;
    logic [CountW-1:0]  count;
  } arp_reply_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [CommandW-1:0] in_command = '0;
  logic [IpW-1:0]      in_ip_address = '0;
  logic [MacW-1:0]     in_mac_address = '0;
  logic                out_valid;
  logic [StatusW-1:0]  out_status;
  logic [MacW-1:0]     out_mac_out;
  logic [IndexW-1:0]   out_entry_index;
  logic [CountW-1:0]   out_entry_count;

  arp_request_t request_q[$];
  arp_reply_t   expected_replies[$];

  logic [IpW-1:0]  cache_ip[TableDepth];
  logic [MacW-1:0] cache_mac[TableDepth];
  int              cache_fill = 0;

  int n_accepted  = 0;
  int n_presented = 0;
  int total_items = 0;
  int gap_left    = 0;
  int cycle_cnt   = 0;
  int mismatches  = 0;

  arp_request_t drv_req;
  arp_reply_t   got_reply;
  arp_reply_t   exp_reply;

  ip_to_mac_table_core #(
    .TABLE_DEPTH(TableDepth)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_ip_address  (in_ip_address),
    .in_mac_address (in_mac_address),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_mac_out    (out_mac_out),
    .out_entry_index(out_entry_index),
    .out_entry_count(out_entry_count)
  );

  always #6 clk = ~clk;

  // lowest matching entry wins; a new pair is appended only while there is room
  function automatic arp_reply_t resolve_request(logic [CommandW-1:0] command,
                                                 logic [IpW-1:0] ip,
                                                 logic [MacW-1:0] mac);
    arp_reply_t rep;
    int         where;
    where = -1;
    rep = '0;
    for (int i = 0; i < cache_fill; i++) begin
      if (where < 0 && cache_ip[i] == ip) begin
        where = i;
      end
    end
    if (command == CMD_LOOKUP) begin
      if (where >= 0) begin
        rep.status = ST_HIT;
        rep.mac = cache_mac[where];
        rep.index = IndexW'(where);
      end else begin
        rep.status = ST_MISS;
      end
    end else if (where >= 0) begin
      cache_mac[where] = mac;
      rep.status = ST_UPDATED;
      rep.index = IndexW'(where);
    end else if (cache_fill < TableDepth) begin
      cache_ip[cache_fill] = ip;
      cache_mac[cache_fill] = mac;
      rep.status = ST_APPENDED;
      rep.index = IndexW'(cache_fill);
      cache_fill++;
    end else begin
      rep.status = ST_FULL;
    end
    rep.count = CountW'(cache_fill);
    return rep;
  endfunction

  function automatic logic [MacW-1:0] rand_mac();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[MacW-1:0];
  endfunction

  task automatic queue_request(logic [CommandW-1:0] command, logic [IpW-1:0] ip,
                               logic [MacW-1:0] mac);
    arp_request_t req;
    req.command = command;
    req.ip = ip;
    req.mac = mac;
    request_q.push_back(req);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!start || n_presented == n_accepted) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (request_q.size() > QuietTail && $urandom_range(0, 3) == 0) begin
          gap_left <= $urandom_range(0, 5);
          start <= 1'b0;
        end else if (request_q.size() > 0) begin
          drv_req = request_q.pop_front();
          in_command <= drv_req.command;
          in_ip_address <= drv_req.ip;
          in_mac_address <= drv_req.mac;
          start <= 1'b1;
          n_presented <= n_presented + 1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end else if (rst_n) begin
      if (out_valid) begin
        if (expected_replies.size() == 0) begin
          $error("result with no item outstanding: status %0d", out_status);
          mismatches++;
        end else begin
          exp_reply = expected_replies.pop_front();
          got_reply.status = out_status;
          got_reply.mac = out_mac_out;
          got_reply.index = out_entry_index;
          got_reply.count = out_entry_count;
          if (got_reply.status !== exp_reply.status) begin
            $error("out_status: expected %0d, actual %0d", exp_reply.status,
                   got_reply.status);
            mismatches++;
          end
          if (got_reply.mac !== exp_reply.mac) begin
            $error("out_mac_out: expected %h, actual %h", exp_reply.mac, got_reply.mac);
            mismatches++;
          end
          if (got_reply.index !== exp_reply.index) begin
            $error("out_entry_index: expected %0d, actual %0d", exp_reply.index,
                   got_reply.index);
            mismatches++;
          end
          if (got_reply.count !== exp_reply.count) begin
            $error("out_entry_count: expected %0d, actual %0d", exp_reply.count,
                   got_reply.count);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        expected_replies.push_back(resolve_request(in_command, in_ip_address,
                                                   in_mac_address));
        n_accepted++;
      end
    end
  end

  initial begin
    logic [IpW-1:0] known_ips[$];
    logic [IpW-1:0] ip;
    int             pick;
    int             sel;

    // empty table, extremes, update and near-miss addresses
    queue_request(CMD_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    queue_request(CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000);
    queue_request(CMD_ADD,    32'h0000_0000, 48'h0000_0000_0000);
    queue_request(CMD_ADD,    32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    queue_request(CMD_LOOKUP, 32'h0000_0000, 48'h1234_5678_9ABC);
    queue_request(CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000);
    queue_request(CMD_ADD,    32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    queue_request(CMD_LOOKUP, 32'h0000_0000, 48'h0000_0000_0000);
    queue_request(CMD_ADD,    32'hA5A5_A5A5, 48'h5A5A_5A5A_5A5A);
    queue_request(CMD_ADD,    32'h5A5A_5A5A, 48'hA5A5_A5A5_A5A5);
    queue_request(CMD_LOOKUP, 32'h5A5A_5A5A, 48'h0000_0000_0000);
    queue_request(CMD_LOOKUP, 32'h5A5A_5A5B, 48'h0000_0000_0000);
    queue_request(CMD_LOOKUP, 32'h8000_0000, 48'h0000_0000_0000);
    queue_request(CMD_ADD,    32'hFFFF_FFFF, 48'h0000_0000_0000);
    queue_request(CMD_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    queue_request(CMD_ADD,    32'hA5A5_A5A5, 48'h8000_0000_0001);
    queue_request(CMD_LOOKUP, 32'hA5A5_A5A5, 48'h0000_0000_0000);
    queue_request(CMD_LOOKUP, 32'h0000_0001, 48'h0000_0000_0000);
    known_ips = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A};

    // mostly known addresses so that hits and updates dominate; the table fills
    // along the way and later adds of new addresses are dropped
    for (int n = 0; n < RandomItems; n++) begin
      sel = $urandom_range(0, 99);
      pick = $urandom_range(0, known_ips.size() - 1);
      if (sel < 40) begin
        queue_request(CMD_LOOKUP, known_ips[pick], rand_mac());
      end else if (sel < 55) begin
        queue_request(CMD_ADD, known_ips[pick], rand_mac());
      end else if (sel < 72) begin
        if ($urandom_range(0, 1) == 0) begin
          ip = $urandom;
        end else begin
          ip = known_ips[pick] ^ (32'd1 << $urandom_range(0, 31));
        end
        queue_request(CMD_ADD, ip, rand_mac());
        if (known_ips.size() < TableDepth + 32) begin
          known_ips.push_back(ip);
        end
      end else if (sel < 90) begin
        if ($urandom_range(0, 1) == 0) begin
          ip = $urandom;
        end else begin
          ip = known_ips[pick] ^ (32'd1 << $urandom_range(0, 31));
        end
        queue_request(CMD_LOOKUP, ip, rand_mac());
      end else begin
        case ($urandom_range(0, 3))
          0: ip = 32'h0000_0000;
          1: ip = 32'hFFFF_FFFF;
          2: ip = 32'h0000_0001 << $urandom_range(0, 31);
          default: ip = ~(32'h0000_0001 << $urandom_range(0, 31));
        endcase
        queue_request(CommandW'($urandom_range(0, 1)), ip,
                      $urandom_range(0, 1) ? 48'hFFFF_FFFF_FFFF : 48'h0000_0000_0000);
      end
    end
    total_items = request_q.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_accepted < total_items) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (expected_replies.size() != 0) begin
      $error("%0d results never arrived", expected_replies.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
